/* sv/bb_pkg.sv */
// Shared types, constants and helpers for the 3x3 box blur.
`default_nettype none
package bb_pkg;

    localparam int PIX_WIDTH        = 8;
    localparam int FW_WIDTH         = 11;
    localparam int FH_WIDTH         = 12;
    localparam int ROW_WIDTH        = 13;
    localparam int CFG_DATA_WIDTH   = 12;
    localparam int CFG_IDX_WIDTH    = 2;
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;
    localparam int COL_SUM_WIDTH    = 10;
    localparam int SUM_WIDTH        = 12;
    localparam int RECIP_WIDTH      = 13;
    localparam int RECIP_SHIFT      = 16;
    localparam int PROD_WIDTH       = SUM_WIDTH + RECIP_WIDTH;

    // ceil(2^16 / 9): exact floor(sum / 9) for every sum up to 9 * 255
    localparam logic [RECIP_WIDTH-1:0] RECIP9 = 13'd7282;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic                 op;
        logic [PIX_WIDTH-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_WIDTH-1:0] pixel_out;
        logic                 frame_last;
    } t_out_item;

    typedef struct packed {
        logic have;
        logic top_ok;
        logic bot_ok;
        logic l_ok;
        logic r_ok;
        logic last;
    } t_tap_flags;

    typedef struct packed {
        logic       go;
        logic       clear;
        t_tap_flags flags;
    } t_win_ctl;

    function automatic logic [COL_SUM_WIDTH-1:0] col_sum(
        input logic [PIX_WIDTH-1:0] top,
        input logic [PIX_WIDTH-1:0] mid,
        input logic [PIX_WIDTH-1:0] bot,
        input logic                 top_ok,
        input logic                 bot_ok
    );
        logic [COL_SUM_WIDTH-1:0] s;
        s = COL_SUM_WIDTH'(mid);
        s = s + (top_ok ? COL_SUM_WIDTH'(top) : '0);
        s = s + (bot_ok ? COL_SUM_WIDTH'(bot) : '0);
        return s;
    endfunction

endpackage
`default_nettype wire

/* sv/bb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module bb_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/bb_window.sv */
// Two-column neighbourhood window and the masked 3x3 sum.
`default_nettype none
module bb_window (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bb_pkg::t_win_ctl                i_ctl,
    input  wire logic [bb_pkg::PIX_WIDTH-1:0]    i_top,
    input  wire logic [bb_pkg::PIX_WIDTH-1:0]    i_mid,
    input  wire logic [bb_pkg::PIX_WIDTH-1:0]    i_bot,
    output logic      [bb_pkg::SUM_WIDTH-1:0]    o_sum
);
    import bb_pkg::*;

    // row 0 top, row 2 newest; column 2 is the most recent one
    logic [PIX_WIDTH-1:0] r_w1 [3];
    logic [PIX_WIDTH-1:0] r_w2 [3];

    logic [COL_SUM_WIDTH-1:0] sum_l, sum_c, sum_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_w1[k] <= '0;
                r_w2[k] <= '0;
            end
        end else if (i_ctl.clear) begin
            for (int k = 0; k < 3; k++) begin
                r_w1[k] <= '0;
                r_w2[k] <= '0;
            end
        end else if (i_ctl.go) begin
            for (int k = 0; k < 3; k++) begin
                r_w1[k] <= r_w2[k];
            end
            r_w2[0] <= i_top;
            r_w2[1] <= i_mid;
            r_w2[2] <= i_bot;
        end
    end

    // right column is the arriving one, dropped at the start of a row
    always_comb begin
        sum_l = col_sum(r_w1[0], r_w1[1], r_w1[2], i_ctl.flags.top_ok, i_ctl.flags.bot_ok);
        sum_c = col_sum(r_w2[0], r_w2[1], r_w2[2], i_ctl.flags.top_ok, i_ctl.flags.bot_ok);
        sum_r = col_sum(i_top, i_mid, i_bot, i_ctl.flags.top_ok, i_ctl.flags.bot_ok);
        o_sum = SUM_WIDTH'(sum_c)
              + (i_ctl.flags.l_ok ? SUM_WIDTH'(sum_l) : '0)
              + (i_ctl.flags.r_ok ? SUM_WIDTH'(sum_r) : '0);
    end

endmodule
`default_nettype wire

/* sv/bb_div9.sv */
// Sum register, divide by nine through a reciprocal, and the output register.
`default_nettype none
module bb_div9 (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [bb_pkg::SUM_WIDTH-1:0]  i_sum,
    input  wire logic                          i_last,
    input  wire logic                          i_stall,
    output logic                               o_free,
    output logic                               o_valid,
    output bb_pkg::t_out_item                  o_data
);
    import bb_pkg::*;

    logic                  r_v2, n_v2, r_ov, n_ov;
    logic [SUM_WIDTH-1:0]  r_sum;
    logic                  r_last2;
    t_out_item             r_out;
    logic                  out_free;
    logic [PROD_WIDTH-1:0] prod;

    assign out_free = !r_ov || !i_stall;
    assign o_free   = !r_v2 || out_free;
    assign prod     = PROD_WIDTH'(r_sum) * PROD_WIDTH'(RECIP9);

    always_comb begin
        n_ov = r_ov;
        if (out_free) begin
            n_ov = r_v2;
        end
        n_v2 = r_v2;
        if (i_load) begin
            n_v2 = 1'b1;
        end else if (out_free) begin
            n_v2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v2 <= n_v2;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum   <= i_sum;
            r_last2 <= i_last;
        end
        if (r_v2 && out_free) begin
            r_out.pixel_out  <= prod[RECIP_SHIFT+PIX_WIDTH-1:RECIP_SHIFT];
            r_out.frame_last <= r_last2;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule
`default_nettype wire

/* sv/box_blur_3x3.sv */
// Top level of the streaming 3x3 box blur: handshakes, counters and line store.
//
// Pixels enter on i_data in raster order, one transfer per i_valid && !o_stall.
// Each result on o_data is floor(3x3 neighbourhood sum / 9) with off-frame
// neighbours as zero; frame_last marks the final pixel of the frame.
// The result for pixel (y, x) comes from the transfer that carries the pixel
// one row plus one pixel later, so after the frame send frame_width + 1
// padding transfers (op = 1) to flush the last row.
// Throughput: one transfer per cycle while the receiver does not stall; the line store is a single
// 16-bit RAM read once and written once per pixel, forwarding the write data
// when consecutive transfers hit one column (one-pixel-wide frame, frame restart).
// After the transfer that completes its neighbourhood, the result passes the RAM
// read, the sum register and the divide before it leaves the output register.
// Receiver stall holds the output register; the sum stage and the line-store
// stage keep filling behind it, and o_stall rises only when they are full.
// Configuration: i_cfg_* writes frame width (index 0) or height (index 1), always
// ready; user writes only while idle, not enforced; either write restarts the frame.
// Reset: synchronous, active low; restores 640 x 480, empties the pipeline
// and clears the window. The line store needs no clearing pass.
`default_nettype none
module box_blur_3x3 #(
    parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire bb_pkg::t_in_item                    i_data,
    output logic                                     o_stall,
    output logic                                     o_valid,
    output bb_pkg::t_out_item                        o_data,
    input  wire logic                                i_stall,
    input  wire logic                                i_cfg_valid,
    input  wire logic [bb_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  wire logic [bb_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output logic                                     o_cfg_ready
);
    import bb_pkg::*;

    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int CW        = (WW > FW_WIDTH) ? WW : FW_WIDTH;
    localparam int MEM_WIDTH = 2 * PIX_WIDTH;

    // width register as last column index, clamped to the line store
    function automatic logic [AW-1:0] eff_wlast(input logic [FW_WIDTH-1:0] fw);
        logic [CW-1:0] fw_ext;
        fw_ext = CW'(fw);
        if (fw_ext == '0) begin
            return '0;
        end else if (fw_ext > CW'(MAX_WIDTH)) begin
            return AW'(MAX_WIDTH - 1);
        end else begin
            return AW'(fw_ext - CW'(1));
        end
    endfunction

    // configuration
    logic [AW-1:0]        r_w_last;
    logic [FH_WIDTH-1:0]  r_h;
    logic [ROW_WIDTH-1:0] h13;
    logic                 cfg_we, cfg_hit;

    // stream position and the line-store stage
    logic [AW-1:0]        r_col, n_col, r_c1;
    logic [ROW_WIDTH-1:0] r_row, n_row;
    logic                 r_v1, n_v1, r_fwd;
    t_tap_flags           r_flags1, acc_flags;
    logic [PIX_WIDTH-1:0] r_pix1, acc_pix;
    logic [MEM_WIDTH-1:0] r_fwd_data, ram_rdata;
    logic [PIX_WIDTH-1:0] s1_top, s1_mid;
    logic                 c_nz;

    logic                 accept, s1_go, s1_free, div_free;
    t_win_ctl             win_ctl;
    logic [SUM_WIDTH-1:0] win_sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_we
                       && (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);
    assign h13         = ROW_WIDTH'(r_h);

    // the line-store stage retires now unless its result has nowhere to go
    assign s1_go   = r_v1 && (!r_flags1.have || div_free);
    assign s1_free = !r_v1 || s1_go;
    assign o_stall = !s1_free;
    assign accept  = i_valid && s1_free;

    // border masks and output placement, worked out from the position at transfer
    always_comb begin
        c_nz = (r_col != '0);
        if (c_nz) begin
            acc_flags.have   = (r_row >= ROW_WIDTH'(1));
            acc_flags.top_ok = (r_row >= ROW_WIDTH'(2));
            acc_flags.bot_ok = (r_row < h13);
            acc_flags.l_ok   = (r_col >= AW'(2));
        end else begin
            acc_flags.have   = (r_row >= ROW_WIDTH'(2));
            acc_flags.top_ok = (r_row >= ROW_WIDTH'(3));
            acc_flags.bot_ok = (r_row <= h13);
            acc_flags.l_ok   = (r_w_last != '0);
        end
        acc_flags.r_ok = c_nz;
        acc_flags.last = !c_nz && (r_row == h13 + ROW_WIDTH'(1));

        // padding inside the image reads as black, pixels past the image are dropped
        acc_pix = ((r_row < h13) && !i_data.op) ? i_data.pixel_in : '0;

        n_col = r_col + AW'(1);
        n_row = r_row;
        if (acc_flags.last) begin
            n_col = '0;
            n_row = '0;
        end else if (r_col == r_w_last) begin
            n_col = '0;
            n_row = r_row + ROW_WIDTH'(1);
        end

        n_v1 = r_v1;
        if (accept) begin
            n_v1 = 1'b1;
        end else if (s1_go) begin
            n_v1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= eff_wlast(FW_WIDTH'(DEF_FRAME_WIDTH));
            r_h      <= FH_WIDTH'(DEF_FRAME_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
            r_v1     <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (cfg_we && i_cfg_index == REG_FRAME_WIDTH) begin
                r_w_last <= eff_wlast(i_cfg_data[FW_WIDTH-1:0]);
            end
            if (cfg_we && i_cfg_index == REG_FRAME_HEIGHT) begin
                r_h <= (i_cfg_data[FH_WIDTH-1:0] == '0) ? FH_WIDTH'(1)
                                                         : i_cfg_data[FH_WIDTH-1:0];
            end
            if (cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_v1 <= n_v1;
            // same column written as it is read: take the write data instead
            if (accept) begin
                r_fwd <= s1_go && (r_c1 == r_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c1       <= r_col;
            r_pix1     <= acc_pix;
            r_flags1   <= acc_flags;
            r_fwd_data <= {s1_mid, r_pix1};
        end
    end

    assign s1_top = r_fwd ? r_fwd_data[MEM_WIDTH-1:PIX_WIDTH] : ram_rdata[MEM_WIDTH-1:PIX_WIDTH];
    assign s1_mid = r_fwd ? r_fwd_data[PIX_WIDTH-1:0]         : ram_rdata[PIX_WIDTH-1:0];

    // upper row in the high byte, lower row in the low byte; rows move up on write
    bb_ram #(
        .WIDTH (MEM_WIDTH),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_c1),
        .i_wdata ({s1_mid, r_pix1}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign win_ctl.go    = s1_go;
    assign win_ctl.clear = cfg_hit || (s1_go && r_flags1.last);
    assign win_ctl.flags = r_flags1;

    bb_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_top   (s1_top),
        .i_mid   (s1_mid),
        .i_bot   (r_pix1),
        .o_sum   (win_sum)
    );

    bb_div9 u_div9 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_go && r_flags1.have),
        .i_sum   (win_sum),
        .i_last  (r_flags1.last),
        .i_stall (i_stall),
        .o_free  (div_free),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_fwd_same_column : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_fwd |-> (r_w_last == '0 || r_c1 == '0))
        else $error("line store forwarding outside a one-pixel frame or a frame restart");

    a_col_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_w_last)
        else $error("column index beyond frame width");

    a_row_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h13 + ROW_WIDTH'(1))
        else $error("row index ran past the flush row");

    a_last_has_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_flags1.last |-> r_flags1.have)
        else $error("frame end flagged on a transfer with no result");

    a_result_has_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_flags1.have |-> div_free)
        else $error("result loaded into a full divide stage");

endmodule
`default_nettype wire
